// ----- sv/drc_pkg.sv -----
package drc_pkg;

    localparam int GRID_DIM_DEF    = 64;
    localparam int SCREEN_COLS_DEF = 320;
    localparam int SCREEN_ROWS_DEF = 240;

    localparam int PROD_W  = 59;
    localparam int DIV_NW  = 42;
    localparam int DIV_DW  = 24;
    localparam int RD_W    = 21;
    localparam int PL_W    = 20;
    localparam int SIDE_W  = 61;
    localparam int DIST_W  = 24;
    localparam int CFG_DW  = 22;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [SIDE_W-1:0] SIDE_INF = SIDE_W'(1) << 60;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CAST = 1'b1;

    localparam logic [2:0] REG_EYE_X       = 3'd0;
    localparam logic [2:0] REG_EYE_Y       = 3'd1;
    localparam logic [2:0] REG_LOOK_X      = 3'd2;
    localparam logic [2:0] REG_LOOK_Y      = 3'd3;
    localparam logic [2:0] REG_SLICE_GAIN  = 3'd4;
    localparam logic [2:0] REG_GRID_WIDTH  = 3'd5;
    localparam logic [2:0] REG_GRID_HEIGHT = 3'd6;
    localparam logic [2:0] REG_VIEW_SPREAD = 3'd7;

    localparam int DIR_POS_Y = 0;
    localparam int DIR_NEG_X = 1;
    localparam int DIR_NEG_Y = 2;
    localparam int DIR_POS_X = 3;

    localparam logic [21:0] EYE_RST    = 22'd98304;
    localparam logic [17:0] LOOKX_RST  = 18'd65536;
    localparam logic [17:0] LOOKY_RST  = 18'd0;
    localparam logic [19:0] GAIN_RST   = 20'd65536;
    localparam logic [6:0]  GRID_RST   = 7'd64;
    localparam logic [16:0] SPREAD_RST = 17'd43254;

    typedef struct packed {
        logic       opcode;
        logic [5:0] cell_col;
        logic [5:0] cell_row;
        logic [3:0] wall_bits;
        logic [8:0] screen_col;
    } t_in_item;

    typedef struct packed {
        logic [8:0]  out_col;
        logic        hit_side;
        logic [5:0]  hit_cell_x;
        logic [5:0]  hit_cell_y;
        logic [23:0] wall_distance;
        logic        escaped;
        logic [7:0]  slice_top;
        logic [7:0]  slice_bottom;
        logic [15:0] tex_fraction;
    } t_out_item;

    typedef struct packed {
        logic [2:0]        reg_idx;
        logic [CFG_DW-1:0] wdata;
    } t_cfg_req;

    function automatic logic signed [PROD_W-1:0] trunc16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] b;
        b = p[PROD_W-1] ? p + PROD_W'(65535) : p;
        return b >>> 16;
    endfunction

endpackage

// ----- sv/drc_ifs.sv -----
interface drc_in_if;
    logic               valid;
    logic               ready;
    drc_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface drc_out_if;
    logic               valid;
    logic               ready;
    drc_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface drc_cfg_if;
    logic               valid;
    logic               ready;
    drc_pkg::t_cfg_req  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/drc_ram.sv -----
module drc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/drc_div.sv -----
module drc_div #(
    parameter int NW = drc_pkg::DIV_NW,
    parameter int DW = drc_pkg::DIV_DW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [$clog2(NW)-1:0] r_cnt, n_cnt;
    logic [DW-1:0]         r_rem, n_rem;
    logic [DW-1:0]         r_den, n_den;
    logic [NW-1:0]         r_quo, n_quo;
    logic [DW:0]           w_sh;
    logic                  w_ge;

    assign w_sh = {r_rem, r_quo[NW-1]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_den  = i_den;
            n_quo  = i_num;
        end else if (r_busy) begin
            n_rem = w_ge ? DW'(w_sh - {1'b0, r_den}) : w_sh[DW-1:0];
            n_quo = {r_quo[NW-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (32'(r_cnt) == NW - 1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ----- sv/dda_ray_column_caster.sv -----
// Grid-walking raycaster over a maze whose cells carry four wall bits.
// Requests arrive on i_in: a load request writes one cell's wall bits into
// the wall store; a cast request names a screen column and produces one
// result on o_out, and a column beyond the screen produces none. Registers
// are written on i_cfg, which is always ready; the user must write them only
// while the block is idle, as the block does not enforce it. Every cell a
// ray can reach must be loaded before a cast. A cast is worked by one shared
// multiplier and one shared divider that retires one quotient bit per cycle,
// under a small sequencer; i_in is not ready from the acceptance of a cast
// until its result is handed to the output register.
// The result sits in an output register, so a finished result that waits
// on a stalled receiver does not block the next request; a second result
// waits in the final state until the register drains.
// Reset loads the default registers and empties the output register; the
// wall store keeps no reset value.
module dda_ray_column_caster #(
    parameter int GRID_DIM    = drc_pkg::GRID_DIM_DEF,
    parameter int SCREEN_COLS = drc_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = drc_pkg::SCREEN_ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    drc_in_if.sink      i_in,
    drc_cfg_if.sink     i_cfg,
    drc_out_if.source   o_out
);
    localparam int CW    = (($clog2(GRID_DIM) > 6) ? $clog2(GRID_DIM) : 6) + 2;
    localparam int AW    = $clog2(GRID_DIM * GRID_DIM);
    localparam int LIMIT = 4 * GRID_DIM + 8;
    localparam int NCW   = $clog2(LIMIT + 1);
    localparam int LHCAP = 2 * SCREEN_ROWS + 2;
    localparam int LH_W  = $clog2(LHCAP + 1);
    localparam int NUMW  = CW + 18;
    localparam int NW    = drc_pkg::DIV_NW;
    localparam int DW    = drc_pkg::DIV_DW;
    localparam int PW    = drc_pkg::PROD_W;
    localparam int RW    = drc_pkg::RD_W;
    localparam int SW    = drc_pkg::SIDE_W;
    localparam int CAM_SH = $clog2(SCREEN_COLS) + 10;
    localparam longint RECIP = ((longint'(1) << (CAM_SH + 17)) + SCREEN_COLS - 1) / SCREEN_COLS;

    localparam logic [4:0] S_IDLE = 5'd0,  S_CAMW = 5'd1,  S_PLX  = 5'd2,  S_PLY  = 5'd3,
                           S_RDX  = 5'd4,  S_RDY  = 5'd5,  S_AXX  = 5'd6,  S_DXW  = 5'd7,
                           S_SXM  = 5'd8,  S_SXS  = 5'd9,  S_AXY  = 5'd10, S_DYW  = 5'd11,
                           S_SYM  = 5'd12, S_SYS  = 5'd13, S_STEP = 5'd14, S_CHK  = 5'd15,
                           S_DIST = 5'd16, S_DSTW = 5'd17, S_TEXM = 5'd18, S_TEXS = 5'd19,
                           S_LHD  = 5'd20, S_LHW  = 5'd21, S_FIN  = 5'd22;

    logic [21:0]              r_eye_x, r_eye_y;
    logic signed [17:0]       r_look_x, r_look_y;
    logic [19:0]              r_gain;
    logic [6:0]               r_grid_w, r_grid_h;
    logic [16:0]              r_spread;

    logic [4:0]               r_state, n_state;
    logic [8:0]               r_col, n_col;
    logic signed [17:0]       r_cam, n_cam;
    logic signed [drc_pkg::PL_W-1:0] r_plx, n_plx, r_ply, n_ply;
    logic signed [RW-1:0]     r_rdx, n_rdx, r_rdy, n_rdy;
    logic [SW-1:0]            r_dx, n_dx, r_dy, n_dy, r_sx, n_sx, r_sy, n_sy;
    logic signed [CW-1:0]     r_mx, n_mx, r_my, n_my;
    logic                     r_side, n_side;
    logic                     r_hit, n_hit;
    logic [NCW-1:0]           r_cnt, n_cnt;
    logic [DW-1:0]            r_perp, n_perp;
    logic [15:0]              r_tex, n_tex;
    logic [LH_W-1:0]          r_lh, n_lh;
    logic signed [PW-1:0]     r_prod;
    logic                     r_dgo, n_dgo;
    logic [NW-1:0]            r_dnum, n_dnum;
    logic [DW-1:0]            r_dden, n_dden;
    logic                     r_ovalid, n_ovalid;
    drc_pkg::t_out_item       r_out, n_out;

    logic signed [33:0]       w_ma;
    logic signed [24:0]       w_mb;
    logic signed [PW-1:0]     w_tr;
    logic                     w_ddone;
    logic [NW-1:0]            w_quo;
    logic                     w_in_acc;
    logic                     w_we;
    logic [AW-1:0]            w_waddr, w_raddr;
    logic [3:0]               w_rdata;
    logic [CW-1:0]            w_gw, w_gh;
    logic [16:0]              w_fracx, w_fracy;
    logic [DW-1:0]            w_magx, w_magy;
    logic [SW:0]              w_sumx, w_sumy;
    logic signed [NUMW-1:0]   w_num;
    logic [NUMW-1:0]          w_nmag;
    logic signed [RW-1:0]     w_rdh;
    logic [DW-1:0]            w_rdhmag;
    logic [15:0]              w_half, w_top, w_bot;

    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye_x  <= drc_pkg::EYE_RST;
            r_eye_y  <= drc_pkg::EYE_RST;
            r_look_x <= drc_pkg::LOOKX_RST;
            r_look_y <= drc_pkg::LOOKY_RST;
            r_gain   <= drc_pkg::GAIN_RST;
            r_grid_w <= drc_pkg::GRID_RST;
            r_grid_h <= drc_pkg::GRID_RST;
            r_spread <= drc_pkg::SPREAD_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.reg_idx)
                drc_pkg::REG_EYE_X:       r_eye_x  <= i_cfg.data.wdata[21:0];
                drc_pkg::REG_EYE_Y:       r_eye_y  <= i_cfg.data.wdata[21:0];
                drc_pkg::REG_LOOK_X:      r_look_x <= i_cfg.data.wdata[17:0];
                drc_pkg::REG_LOOK_Y:      r_look_y <= i_cfg.data.wdata[17:0];
                drc_pkg::REG_SLICE_GAIN:  r_gain   <= i_cfg.data.wdata[19:0];
                drc_pkg::REG_GRID_WIDTH:  r_grid_w <= i_cfg.data.wdata[6:0];
                drc_pkg::REG_GRID_HEIGHT: r_grid_h <= i_cfg.data.wdata[6:0];
                drc_pkg::REG_VIEW_SPREAD: r_spread <= i_cfg.data.wdata[16:0];
                default: ;
            endcase
        end
    end

    assign w_gw = (r_grid_w == '0) ? CW'(1) :
                  (32'(r_grid_w) > GRID_DIM) ? CW'(GRID_DIM) : CW'(r_grid_w);
    assign w_gh = (r_grid_h == '0) ? CW'(1) :
                  (32'(r_grid_h) > GRID_DIM) ? CW'(GRID_DIM) : CW'(r_grid_h);

    assign w_we = w_in_acc && (i_in.data.opcode == drc_pkg::OP_LOAD) &&
                  (32'(i_in.data.cell_col) < GRID_DIM) && (32'(i_in.data.cell_row) < GRID_DIM);
    assign w_waddr = AW'(int'(i_in.data.cell_row) * GRID_DIM + int'(i_in.data.cell_col));
    assign w_raddr = AW'(int'(n_my) * GRID_DIM + int'(n_mx));

    drc_ram #(
        .WIDTH (4),
        .DEPTH (GRID_DIM * GRID_DIM)
    ) u_walls (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in.data.wall_bits),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    drc_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dgo),
        .i_num   (r_dnum),
        .i_den   (r_dden),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_CAMW: begin
                w_ma = 34'(RECIP);
                w_mb = 25'(r_col);
            end
            S_PLX: begin
                w_ma = -34'(r_look_y);
                w_mb = 25'(r_spread);
            end
            S_PLY: begin
                w_ma = 34'(r_look_x);
                w_mb = 25'(r_spread);
            end
            S_RDX: begin
                w_ma = 34'(r_plx);
                w_mb = 25'(r_cam);
            end
            S_RDY: begin
                w_ma = 34'(r_ply);
                w_mb = 25'(r_cam);
            end
            S_SXM: begin
                w_ma = $signed({1'b0, r_dx[32:0]});
                w_mb = 25'(w_fracx);
            end
            S_SYM: begin
                w_ma = $signed({1'b0, r_dy[32:0]});
                w_mb = 25'(w_fracy);
            end
            S_TEXM: begin
                w_ma = r_side ? 34'(r_rdx) : 34'(r_rdy);
                w_mb = $signed({1'b0, r_perp});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(w_ma * w_mb);
    end

    assign w_tr    = drc_pkg::trunc16(r_prod);
    assign w_fracx = r_rdx[RW-1] ? {1'b0, r_eye_x[15:0]} : 17'h10000 - {1'b0, r_eye_x[15:0]};
    assign w_fracy = r_rdy[RW-1] ? {1'b0, r_eye_y[15:0]} : 17'h10000 - {1'b0, r_eye_y[15:0]};
    assign w_magx  = DW'($unsigned(r_rdx[RW-1] ? -r_rdx : r_rdx));
    assign w_magy  = DW'($unsigned(r_rdy[RW-1] ? -r_rdy : r_rdy));
    assign w_sumx  = {1'b0, r_sx} + {1'b0, r_dx};
    assign w_sumy  = {1'b0, r_sy} + {1'b0, r_dy};
    assign w_rdh   = r_side ? r_rdy : r_rdx;
    assign w_rdhmag = r_side ? w_magy : w_magx;
    assign w_num   = r_side ?
        (NUMW'(r_my) <<< 16) - $signed(NUMW'(r_eye_y)) + (r_rdy[RW-1] ? NUMW'(65536) : '0) :
        (NUMW'(r_mx) <<< 16) - $signed(NUMW'(r_eye_x)) + (r_rdx[RW-1] ? NUMW'(65536) : '0);
    assign w_nmag  = $unsigned(w_num[NUMW-1] ? -w_num : w_num);
    assign w_half  = 16'(r_lh >> 1);
    assign w_top   = (32'(w_half) < SCREEN_ROWS / 2) ? 16'(SCREEN_ROWS / 2) - w_half : '0;
    assign w_bot   = (32'(w_half) + SCREEN_ROWS / 2 >= SCREEN_ROWS) ? 16'(SCREEN_ROWS - 1) :
                     w_half + 16'(SCREEN_ROWS / 2);

    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_cam    = r_cam;
        n_plx    = r_plx;
        n_ply    = r_ply;
        n_rdx    = r_rdx;
        n_rdy    = r_rdy;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_sx     = r_sx;
        n_sy     = r_sy;
        n_mx     = r_mx;
        n_my     = r_my;
        n_side   = r_side;
        n_hit    = r_hit;
        n_cnt    = r_cnt;
        n_perp   = r_perp;
        n_tex    = r_tex;
        n_lh     = r_lh;
        n_dgo    = 1'b0;
        n_dnum   = r_dnum;
        n_dden   = r_dden;
        n_ovalid = r_ovalid && !o_out.ready;
        n_out    = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in.data.opcode == drc_pkg::OP_CAST) &&
                    (32'(i_in.data.screen_col) < SCREEN_COLS)) begin
                    n_col   = i_in.data.screen_col;
                    n_mx    = CW'(r_eye_x[21:16]);
                    n_my    = CW'(r_eye_y[21:16]);
                    n_cnt   = '0;
                    n_side  = 1'b0;
                    n_hit   = 1'b0;
                    n_tex   = '0;
                    n_state = S_CAMW;
                end
            end
            S_CAMW: n_state = S_PLX;
            S_PLX: begin
                n_cam   = $signed(18'(r_prod >>> CAM_SH)) - 18'sd65536;
                n_state = S_PLY;
            end
            S_PLY: begin
                n_plx   = drc_pkg::PL_W'(w_tr);
                n_state = S_RDX;
            end
            S_RDX: begin
                n_ply   = drc_pkg::PL_W'(w_tr);
                n_state = S_RDY;
            end
            S_RDY: begin
                n_rdx   = RW'(r_look_x) + RW'(w_tr);
                n_state = S_AXX;
            end
            S_AXX: begin
                n_rdy = RW'(r_look_y) + RW'(w_tr);
                if (r_rdx == '0) begin
                    n_dx    = drc_pkg::SIDE_INF;
                    n_sx    = drc_pkg::SIDE_INF;
                    n_state = S_AXY;
                end else begin
                    n_dnum  = NW'(1) << 32;
                    n_dden  = w_magx;
                    n_dgo   = 1'b1;
                    n_state = S_DXW;
                end
            end
            S_DXW: begin
                if (w_ddone) begin
                    n_dx    = SW'(w_quo);
                    n_state = S_SXM;
                end
            end
            S_SXM: n_state = S_SXS;
            S_SXS: begin
                n_sx    = SW'(r_prod >>> 16);
                n_state = S_AXY;
            end
            S_AXY: begin
                if (r_rdy == '0) begin
                    n_dy    = drc_pkg::SIDE_INF;
                    n_sy    = drc_pkg::SIDE_INF;
                    n_state = S_STEP;
                end else begin
                    n_dnum  = NW'(1) << 32;
                    n_dden  = w_magy;
                    n_dgo   = 1'b1;
                    n_state = S_DYW;
                end
            end
            S_DYW: begin
                if (w_ddone) begin
                    n_dy    = SW'(w_quo);
                    n_state = S_SYM;
                end
            end
            S_SYM: n_state = S_SYS;
            S_SYS: begin
                n_sy    = SW'(r_prod >>> 16);
                n_state = S_STEP;
            end
            S_STEP: begin
                if (r_sx < r_sy) begin
                    n_sx   = (w_sumx > {1'b0, drc_pkg::SIDE_INF}) ? drc_pkg::SIDE_INF : w_sumx[SW-1:0];
                    n_mx   = r_rdx[RW-1] ? r_mx - CW'(1) : r_mx + CW'(1);
                    n_side = 1'b0;
                end else begin
                    n_sy   = (w_sumy > {1'b0, drc_pkg::SIDE_INF}) ? drc_pkg::SIDE_INF : w_sumy[SW-1:0];
                    n_my   = r_rdy[RW-1] ? r_my - CW'(1) : r_my + CW'(1);
                    n_side = 1'b1;
                end
                if (n_mx[CW-1] || (n_mx >= $signed(w_gw)) || n_my[CW-1] || (n_my >= $signed(w_gh))) begin
                    n_perp  = DW'(drc_pkg::DIST_MAX);
                    n_state = S_LHD;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_side ? w_rdata[r_rdy[RW-1] ? drc_pkg::DIR_NEG_Y : drc_pkg::DIR_POS_Y]
                           : w_rdata[r_rdx[RW-1] ? drc_pkg::DIR_NEG_X : drc_pkg::DIR_POS_X]) begin
                    n_hit   = 1'b1;
                    n_state = S_DIST;
                end else if (32'(r_cnt) == LIMIT - 1) begin
                    n_perp  = DW'(drc_pkg::DIST_MAX);
                    n_state = S_LHD;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_STEP;
                end
            end
            S_DIST: begin
                if (w_rdh == '0) begin
                    n_perp  = DW'(drc_pkg::DIST_MAX);
                    n_state = S_TEXM;
                end else if ((w_num[NUMW-1] != w_rdh[RW-1]) && (w_num != '0)) begin
                    n_perp  = '0;
                    n_state = S_TEXM;
                end else begin
                    n_dnum  = NW'(w_nmag) << 16;
                    n_dden  = w_rdhmag;
                    n_dgo   = 1'b1;
                    n_state = S_DSTW;
                end
            end
            S_DSTW: begin
                if (w_ddone) begin
                    n_perp  = (w_quo > NW'(drc_pkg::DIST_MAX)) ? DW'(drc_pkg::DIST_MAX) : DW'(w_quo);
                    n_state = S_TEXM;
                end
            end
            S_TEXM: n_state = S_TEXS;
            S_TEXS: begin
                n_tex   = (r_side ? r_eye_x[15:0] : r_eye_y[15:0]) + w_tr[15:0];
                n_state = S_LHD;
            end
            S_LHD: begin
                if (r_perp == '0) begin
                    n_lh    = LH_W'(LHCAP);
                    n_state = S_FIN;
                end else begin
                    n_dnum  = NW'(SCREEN_ROWS) * NW'(r_gain);
                    n_dden  = r_perp;
                    n_dgo   = 1'b1;
                    n_state = S_LHW;
                end
            end
            S_LHW: begin
                if (w_ddone) begin
                    n_lh    = (w_quo > NW'(LHCAP)) ? LH_W'(LHCAP) : LH_W'(w_quo);
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid            = 1'b1;
                    n_out.out_col       = r_col;
                    n_out.hit_side      = r_side;
                    n_out.hit_cell_x    = r_hit ? r_mx[5:0] : '0;
                    n_out.hit_cell_y    = r_hit ? r_my[5:0] : '0;
                    n_out.wall_distance = r_perp;
                    n_out.escaped       = !r_hit;
                    n_out.slice_top     = w_top[7:0];
                    n_out.slice_bottom  = w_bot[7:0];
                    n_out.tex_fraction  = r_tex;
                    n_state             = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_dgo    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_dgo    <= n_dgo;
        end
        r_col  <= n_col;
        r_cam  <= n_cam;
        r_plx  <= n_plx;
        r_ply  <= n_ply;
        r_rdx  <= n_rdx;
        r_rdy  <= n_rdy;
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_sx   <= n_sx;
        r_sy   <= n_sy;
        r_mx   <= n_mx;
        r_my   <= n_my;
        r_side <= n_side;
        r_hit  <= n_hit;
        r_cnt  <= n_cnt;
        r_perp <= n_perp;
        r_tex  <= n_tex;
        r_lh   <= n_lh;
        r_dnum <= n_dnum;
        r_dden <= n_dden;
        r_out  <= n_out;
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;
endmodule
